// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files of the servo sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that the antecedent implies the consequent in the same cycle.
`define SQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  `SQ_ASSERT(label, clk, rst, (ante) |-> (cons), msg)

`endif

// ----- rtl/stsq_pkg.sv -----
// Types, constants and register codes of the servo overshoot move sequencer.
package stsq_pkg;

  localparam int TIME_W   = 32;  // timestamp width, differences wrap at this width
  localparam int ANGLE_W  = 8;
  localparam int SPEED_W  = 24;
  localparam int OVER_W   = 5;
  localparam int HOLD_W   = 11;
  localparam int CFG_W    = 24;  // widest register
  localparam int CFG_IDX_W = 2;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;
  localparam logic [ANGLE_W-1:0] STEP_MAX  = 8'd255;

  localparam logic [SPEED_W-1:0] SPEED_RESET = 24'd19661;  // 0.3 deg/ms in Q8.16
  localparam logic [OVER_W-1:0]  OVER_RESET  = 5'd5;
  localparam logic [HOLD_W-1:0]  HOLD_RESET  = 11'd300;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD  = 2'd2;

  // Item kinds
  localparam logic FUNC_MOVE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_TO_OVER = 2'd1,
    PH_HOLD    = 2'd2,
    PH_RETURN  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [OVER_W-1:0]  overshoot;
    logic [HOLD_W-1:0]  hold_ms;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic               strobe;
    logic               busy;
    logic [ANGLE_W-1:0] position;
  } result_t;

endpackage

// ----- rtl/servo_overshoot_move_sequencer_unit.sv -----
// Top level of the servo overshoot move sequencer: stream ports, registers, assertions.
//
// Servo overshoot move sequencer. A move item (tuser 0) sets the target, clamped to
// 180 degrees, and starts a slew toward target plus overshoot (capped at 180). A tick
// item (tuser 1) carries a millisecond timestamp; each tick advances the position by
// floor(elapsed * speed / 65536), saturated to 255, where elapsed counts from the last
// step, move or hold expiry. At the overshoot point the block holds for hold_delay_ms,
// then slews back to the target and goes idle. Every item returns exactly one result.
// Rate: one item per clock while the result side does not stall; each item passes the
// input register, then the result register. The rate is set by the state update loop
// (a 32x24 multiply, slew and phase compare), which is combinational between the input
// register and the result register.
// Configuration must be written only while the block is idle; the block itself does not
// enforce it. An index past the last register is ignored.
`include "assert_macros.svh"

module servo_overshoot_move_sequencer_unit (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [39:0]                    s_tdata,   // [7:0] angle, [39:8] now_ms
  input  logic                           s_tuser,   // [0] func
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [15:0]                    m_tdata,   // [7:0] position, [8] busy_res,
                                                    // [9] drive_strobe, [11:10] phase
  // configuration write port
  input  logic                           cfg_we,
  input  logic [stsq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stsq_pkg::CFG_W-1:0]     cfg_data
);
  import stsq_pkg::*;

  cfg_t               cfg;
  logic               in_valid;
  logic               in_func;
  logic [ANGLE_W-1:0] in_angle;
  logic [TIME_W-1:0]  in_now;
  logic               fire;
  result_t            res;
  result_t            out_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed     <= SPEED_RESET;
      cfg.overshoot <= OVER_RESET;
      cfg.hold_ms   <= HOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPEED: cfg.speed     <= cfg_data[SPEED_W-1:0];
        CFG_OVER:  cfg.overshoot <= cfg_data[OVER_W-1:0];
        CFG_HOLD:  cfg.hold_ms   <= cfg_data[HOLD_W-1:0];
        default:   ;
      endcase
    end
  end

  // Process the held item whenever the result register is free or draining.
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  // Input register: take a new transfer while the previous item advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func  <= s_tuser;
      in_angle <= s_tdata[ANGLE_W-1:0];
      in_now   <= s_tdata[ANGLE_W+TIME_W-1:ANGLE_W];
    end
  end

  stsq_engine u_engine (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .func  (in_func),
    .angle (in_angle),
    .now   (in_now),
    .cfg   (cfg),
    .res   (res)
  );

  // Result register: load on fire, drop valid once the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_res <= res;
  end

  assign m_tdata = {4'b0000, out_res};

  // Input side keeps accepting whenever the result side is not stalled.
  `SQ_ASSERT_IMP(a_ready_when_flowing, clk, rst, !(m_tvalid && !m_tready), s_tready, "input stalled while output flows")
  // A held item is never dropped without being processed.
  `SQ_ASSERT(a_item_kept, clk, rst, (in_valid && !fire) |=> in_valid, "held item lost")
  // Busy flag matches the reported phase.
  `SQ_ASSERT_IMP(a_busy_phase, clk, rst, m_tvalid, out_res.busy == (out_res.phase != PH_IDLE), "busy and phase disagree")
  // Commanded position stays within the servo range.
  `SQ_ASSERT_IMP(a_pos_range, clk, rst, m_tvalid, out_res.position <= ANGLE_MAX, "position above 180")

endmodule

// ----- rtl/stsq_step.sv -----
// Step size: elapsed time times Q8.16 speed, truncated and saturated to 255.
module stsq_step (
  input  logic [stsq_pkg::TIME_W-1:0]  elapsed,
  input  logic [stsq_pkg::SPEED_W-1:0] speed,
  output logic [stsq_pkg::ANGLE_W-1:0] step
);
  import stsq_pkg::*;

  localparam int PROD_W = TIME_W + SPEED_W;
  localparam int FRAC_W = 16;

  logic [PROD_W-1:0] prod;

  assign prod = {{SPEED_W{1'b0}}, elapsed} * {{TIME_W{1'b0}}, speed};

  // Saturate when any bit above the integer byte is set.
  assign step = (prod[PROD_W-1:FRAC_W+ANGLE_W] != '0) ? STEP_MAX
                                                      : prod[FRAC_W+ANGLE_W-1:FRAC_W];

endmodule

// ----- rtl/stsq_engine.sv -----
// Sequencer state and the combinational next-state logic for one item.
module stsq_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic                         func,
  input  logic [stsq_pkg::ANGLE_W-1:0] angle,
  input  logic [stsq_pkg::TIME_W-1:0]  now,
  input  stsq_pkg::cfg_t               cfg,
  output stsq_pkg::result_t            res
);
  import stsq_pkg::*;

  logic [ANGLE_W-1:0] cur_pos, cur_pos_next;
  logic [ANGLE_W-1:0] target, target_next;
  phase_t             phase, phase_next;
  logic [TIME_W-1:0]  last_step, last_step_next;
  logic [TIME_W-1:0]  hold_start, hold_start_next;
  logic               strobe;

  logic [TIME_W-1:0]  elapsed;
  logic [TIME_W-1:0]  held;
  logic [ANGLE_W-1:0] step;
  logic [ANGLE_W:0]   over_sum;
  logic [ANGLE_W-1:0] over_goal;
  logic [ANGLE_W-1:0] goal;
  logic [ANGLE_W:0]   up_sum;
  logic [ANGLE_W-1:0] down_gap;
  logic [ANGLE_W-1:0] slewed;
  logic [ANGLE_W-1:0] clamped;
  logic               slewing;
  logic               stepping;
  logic               arrived;
  logic               hold_done;

  assign elapsed = now - last_step;
  assign held    = now - hold_start;

  stsq_step u_step (
    .elapsed (elapsed),
    .speed   (cfg.speed),
    .step    (step)
  );

  assign clamped   = (angle > ANGLE_MAX) ? ANGLE_MAX : angle;
  assign over_sum  = {1'b0, target} + {{(ANGLE_W+1-OVER_W){1'b0}}, cfg.overshoot};
  assign over_goal = (over_sum > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : over_sum[ANGLE_W-1:0];
  assign goal      = (phase == PH_TO_OVER) ? over_goal : target;

  // Move toward the goal by at most one step, never past it.
  assign up_sum   = {1'b0, cur_pos} + {1'b0, step};
  assign down_gap = cur_pos - goal;
  always_comb begin
    if (cur_pos < goal) begin
      slewed = (up_sum > {1'b0, goal}) ? goal : up_sum[ANGLE_W-1:0];
    end else if (cur_pos > goal) begin
      slewed = (down_gap > step) ? (cur_pos - step) : goal;
    end else begin
      slewed = cur_pos;
    end
  end

  assign slewing   = (phase == PH_TO_OVER) || (phase == PH_RETURN);
  assign stepping  = (func == FUNC_TICK) && slewing && (step != '0);
  assign arrived   = (slewed == goal);
  assign hold_done = (held >= TIME_W'(cfg.hold_ms));

  // Next phase
  always_comb begin
    phase_next = phase;
    if (func == FUNC_MOVE) begin
      phase_next = PH_TO_OVER;
    end else begin
      unique case (phase)
        PH_IDLE:    phase_next = PH_IDLE;
        PH_TO_OVER: if (stepping && arrived) phase_next = PH_HOLD;
        PH_HOLD:    if (hold_done) phase_next = PH_RETURN;
        PH_RETURN:  if (stepping && arrived) phase_next = PH_IDLE;
      endcase
    end
  end

  // Datapath next values
  always_comb begin
    cur_pos_next    = cur_pos;
    target_next     = target;
    last_step_next  = last_step;
    hold_start_next = hold_start;
    strobe          = 1'b0;
    if (func == FUNC_MOVE) begin
      target_next    = clamped;
      last_step_next = now;
    end else if (stepping) begin
      cur_pos_next   = slewed;
      strobe         = 1'b1;
      last_step_next = now;
      if (phase == PH_TO_OVER && arrived) hold_start_next = now;
    end else if (phase == PH_HOLD && hold_done) begin
      last_step_next = now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_pos   <= '0;
      target    <= '0;
      phase     <= PH_IDLE;
      last_step <= '0;
    end else if (fire) begin
      cur_pos   <= cur_pos_next;
      target    <= target_next;
      phase     <= phase_next;
      last_step <= last_step_next;
    end
  end

  // Written on entry to the hold before it is ever read.
  always_ff @(posedge clk) begin
    if (fire) hold_start <= hold_start_next;
  end

  assign res.position = cur_pos_next;
  assign res.busy     = (phase_next != PH_IDLE);
  assign res.strobe   = strobe;
  assign res.phase    = phase_next;

endmodule

// ----- bench/servo_sequencer_checker.sv -----
// Checker for the servo sequencer: predicts each result and compares it with the block.
`timescale 1ns / 100ps
module servo_sequencer_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [39:0]                    s_tdata,
  input  logic                           s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [15:0]                    m_tdata,
  input  logic                           cfg_we,
  input  logic [stsq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stsq_pkg::CFG_W-1:0]     cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import stsq_pkg::*;

  logic [SPEED_W-1:0] speed_q16;
  logic [OVER_W-1:0]  over_deg;
  logic [HOLD_W-1:0]  hold_ms;

  logic [ANGLE_W-1:0] servo_pos;
  logic [ANGLE_W-1:0] target_pos;
  phase_t             motion;
  logic [TIME_W-1:0]  last_step_ms;
  logic [TIME_W-1:0]  hold_start_ms;

  result_t expected_results[$];
  result_t got;
  result_t want;

  function automatic logic [ANGLE_W-1:0] step_degrees(input logic [TIME_W-1:0] elapsed);
    logic [TIME_W+SPEED_W-1:0] prod;
    prod = {{SPEED_W{1'b0}}, elapsed} * {{TIME_W{1'b0}}, speed_q16};
    prod = prod >> 16;
    return (prod[TIME_W+SPEED_W-1:ANGLE_W] != '0) ? STEP_MAX : prod[ANGLE_W-1:0];
  endfunction

  task automatic predict_servo_result(input logic func, input logic [ANGLE_W-1:0] angle,
                                      input logic [TIME_W-1:0] now, output result_t res);
    logic [ANGLE_W-1:0] step;
    logic [ANGLE_W-1:0] goal;
    logic [ANGLE_W:0]   sum;
    logic               strobe;
    strobe = 1'b0;
    if (func == FUNC_MOVE) begin
      target_pos   = (angle > ANGLE_MAX) ? ANGLE_MAX : angle;
      motion       = PH_TO_OVER;
      last_step_ms = now;
    end else if (motion == PH_TO_OVER || motion == PH_RETURN) begin
      step = step_degrees(now - last_step_ms);
      if (step != '0) begin
        goal = target_pos;
        if (motion == PH_TO_OVER) begin
          sum  = {1'b0, target_pos} + {{(ANGLE_W+1-OVER_W){1'b0}}, over_deg};
          goal = (sum > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : sum[ANGLE_W-1:0];
        end
        if (servo_pos < goal) begin
          sum       = {1'b0, servo_pos} + {1'b0, step};
          servo_pos = (sum > {1'b0, goal}) ? goal : sum[ANGLE_W-1:0];
        end else if (servo_pos > goal) begin
          servo_pos = ((servo_pos - goal) > step) ? servo_pos - step : goal;
        end
        strobe       = 1'b1;
        last_step_ms = now;
        if (servo_pos == goal) begin
          if (motion == PH_TO_OVER) begin
            motion        = PH_HOLD;
            hold_start_ms = now;
          end else begin
            motion = PH_IDLE;
          end
        end
      end
    end else if (motion == PH_HOLD) begin
      if ((now - hold_start_ms) >= TIME_W'(hold_ms)) begin
        motion       = PH_RETURN;
        last_step_ms = now;
      end
    end
    res.position = servo_pos;
    res.busy     = (motion != PH_IDLE);
    res.strobe   = strobe;
    res.phase    = motion;
  endtask

  task automatic note_failure(input string what, input result_t exp_r, input result_t act_r,
                              input logic have_exp);
    fail_count++;
    if (fail_count <= 10) begin
      if (have_exp)
        $display("%t %s: expected pos %0d busy %0d strobe %0d phase %0d, got pos %0d busy %0d strobe %0d phase %0d",
                 $realtime, what, exp_r.position, exp_r.busy, exp_r.strobe, exp_r.phase,
                 act_r.position, act_r.busy, act_r.strobe, act_r.phase);
      else
        $display("%t %s: got pos %0d busy %0d strobe %0d phase %0d", $realtime, what,
                 act_r.position, act_r.busy, act_r.strobe, act_r.phase);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      speed_q16     = SPEED_RESET;
      over_deg      = OVER_RESET;
      hold_ms       = HOLD_RESET;
      servo_pos     = '0;
      target_pos    = '0;
      motion        = PH_IDLE;
      last_step_ms  = '0;
      hold_start_ms = '0;
      expected_results.delete();
      fail_count    = 0;
    end else begin
      // Check the result side first: a result never belongs to an item accepted at this edge.
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[11:0]);
        if (expected_results.size() == 0) begin
          note_failure("result with nothing expected", got, got, 1'b0);
        end else begin
          want = expected_results.pop_front();
          if (got.position != want.position || got.busy != want.busy ||
              got.strobe != want.strobe || got.phase != want.phase)
            note_failure("result mismatch", want, got, 1'b1);
        end
      end
      if (s_tvalid && s_tready) begin
        predict_servo_result(s_tuser, s_tdata[7:0], s_tdata[39:8], want);
        expected_results.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SPEED: speed_q16 = cfg_data[SPEED_W-1:0];
          CFG_OVER:  over_deg  = cfg_data[OVER_W-1:0];
          CFG_HOLD:  hold_ms   = cfg_data[HOLD_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_results.size();
  end

endmodule

// ----- bench/servo_overshoot_move_sequencer_unit_tb.sv -----
// Testbench top for the servo sequencer: stimulus, idling, configuration and verdict.
`timescale 1ns / 100ps
module servo_overshoot_move_sequencer_unit_tb;
  import stsq_pkg::*;

  // Index past the last register; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int PHASES    = 7;
  localparam int PER_PHASE = 120;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [39:0]          s_tdata   = '0;
  logic                 s_tuser   = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [15:0]          m_tdata;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int fail_count;
  int pending;

  int unsigned        send_idle_pct  = 0;
  int unsigned        recv_stall_pct = 0;
  logic [TIME_W-1:0]  now_ms;        // running timestamp of the stimulus
  logic [SPEED_W-1:0] speed_now;     // shadow of the written speed, used to size time gaps
  logic [HOLD_W-1:0]  hold_now;

  logic [SPEED_W-1:0] phase_speed [PHASES] = '{24'd19661, 24'd11796480, 24'd1, 24'hFFFFFF,
                                               24'd0, 24'd65536, 24'd0};
  logic [OVER_W-1:0]  phase_over  [PHASES] = '{5'd5, 5'd20, 5'd0, 5'd31, 5'd5, 5'd10, 5'd0};
  logic [HOLD_W-1:0]  phase_hold  [PHASES] = '{11'd300, 11'd0, 11'd2000, 11'd2047, 11'd10,
                                               11'd50, 11'd0};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  servo_overshoot_move_sequencer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [7:0] angle, [39:8] now_ms
    .s_tuser   (s_tuser),    // [0] func
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // [7:0] position, [8] busy_res, [9] drive_strobe, [11:10] phase
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  servo_sequencer_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Stall the result side at random; the pick is redrawn every cycle.
  always @(negedge clk) begin
    m_tready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Pick one of the idling modes: none, sender only, receiver only, both lightly.
  task automatic set_idling(input int mode);
    case (mode)
      1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
      3:       begin send_idle_pct = 13; recv_stall_pct = 13; end
      default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  // Offer one item starting at a falling edge and hold it until the transfer; return at a
  // falling edge with tvalid still high so the next item can follow without a gap.
  task automatic send_item(input logic func, input logic [ANGLE_W-1:0] angle);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {now_ms, angle};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Advance time and send a tick; the angle field is ignored by the block, so fill it randomly.
  task automatic tick(input logic [TIME_W-1:0] gap);
    now_ms = now_ms + gap;
    send_item(FUNC_TICK, ANGLE_W'($urandom_range(0, 255)));
  endtask

  task automatic move(input logic [ANGLE_W-1:0] angle, input logic [TIME_W-1:0] gap);
    now_ms = now_ms + gap;
    send_item(FUNC_MOVE, angle);
  endtask

  // Time gap for the next item: mostly sized so a tick moves a few degrees at the current
  // speed, some sized to the hold time, some tiny, some huge jumps that wrap the clock.
  function automatic logic [TIME_W-1:0] next_gap();
    int unsigned pick;
    int unsigned typ;
    pick = $urandom_range(0, 99);
    typ  = (speed_now == 0) ? 1000 : 655360 / speed_now + 1;
    if (pick < 50)      return $urandom_range(0, 2 * typ);
    else if (pick < 78) return $urandom_range(0, hold_now / 4 + 1);
    else if (pick < 90) return $urandom_range(0, 3);
    else if (pick < 97) return $urandom_range(0, 1 << 20);
    else                return $urandom;
  endfunction

  // Drop tvalid and wait for every outstanding result, then let the input and result registers drain.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Write all three registers back to back, plus the unused index when asked.
  task automatic load_config(input logic [SPEED_W-1:0] speed, input logic [OVER_W-1:0] over,
                             input logic [HOLD_W-1:0] hold, input logic poke_unused);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SPEED;
    cfg_data  <= CFG_W'(speed);
    @(negedge clk);
    cfg_index <= CFG_OVER;
    cfg_data  <= CFG_W'(over);
    @(negedge clk);
    cfg_index <= CFG_HOLD;
    cfg_data  <= CFG_W'(hold);
    @(negedge clk);
    if (poke_unused) begin
      cfg_index <= CFG_UNUSED;
      cfg_data  <= CFG_W'($urandom);
      @(negedge clk);
    end
    cfg_we    <= 1'b0;
    speed_now = speed;
    hold_now  = hold;
  endtask

  initial begin
    int items;
    int burst;
    int waited;
    logic [SPEED_W-1:0] spd;
    logic [OVER_W-1:0]  ovr;
    logic [HOLD_W-1:0]  hld;

    now_ms    = '0;
    speed_now = SPEED_RESET;
    hold_now  = HOLD_RESET;
    set_idling(0);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part on the reset configuration (0.3 deg/ms, overshoot 5, hold 300 ms).
    tick(5);                   // tick while idle
    move(8'd255, 5);           // target clamps to 180, overshoot point capped at 180
    tick(3);                   // 0.9 degree: below one degree, no strobe
    tick(1);                   // elapsed accumulates to 4 ms: one degree
    now_ms = 32'hFFFF_FF00;
    tick(0);                   // huge elapsed saturates the step, reach 180, enter hold
    tick(100);                 // still holding
    tick(204);                 // timestamp wraps past zero, hold done, start return
    tick(16);                  // already at the target: strobe, then go idle
    move(8'd0, 16);            // overshoot point is 5
    tick(100);                 // 30 degrees down
    move(8'd200, 5);           // move while busy restarts from the current position
    move(8'd90, 5);
    tick(1000);                // step saturates, land on 95 and hold
    tick(300);                 // hold expires exactly at the delay
    tick(10);                  // return by 3 degrees
    tick(100);                 // reach 90, idle
    move(8'd0, 1);
    tick(2000);
    tick(0);                   // zero elapsed during hold
    tick(400);
    tick(4000);                // back to zero, idle
    move(8'd180, 7);
    tick(32'hFFFF_FFFF);       // largest gap the timestamp allows

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      if (ph == PHASES - 1) begin
        spd = SPEED_W'($urandom_range(1000, 200000));
        ovr = OVER_W'($urandom_range(0, 20));
        hld = HOLD_W'($urandom_range(0, 2000));
      end else begin
        spd = phase_speed[ph];
        ovr = phase_over[ph];
        hld = phase_hold[ph];
      end
      load_config(spd, ovr, hld, ph == 3);
      items = 0;
      while (items < PER_PHASE) begin
        // Each burst is a move followed by ticks, with the odd stray move mixed in.
        set_idling($urandom_range(0, 3));
        move(ANGLE_W'($urandom_range(0, 255)), next_gap());
        items++;
        burst = $urandom_range(3, 40);
        repeat (burst) begin
          if ($urandom_range(0, 19) == 0)
            move(ANGLE_W'($urandom_range(0, 255)), next_gap());
          else
            tick(next_gap());
          items++;
        end
      end
    end

    s_tvalid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

endmodule
